FILE: hdl/otdl_pkg.sv
`default_nettype none
package otdl_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int DIST_BITS_DEF  = 16;

  localparam int PT_W      = 6;
  localparam int PC_W      = 7;
  localparam int IN_DIST_W = 16;
  localparam int LEN_W     = 22;
  localparam int MASK_W    = 64;
  localparam int CHUNK_W   = 8;
  localparam int NCHUNK    = MASK_W / CHUNK_W;
  localparam int CIDX_W    = $clog2(NCHUNK);
  localparam int SUB_W     = $clog2(CHUNK_W);

  localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};
  localparam logic [PC_W-1:0]  PC_RESET = 7'd6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PATH  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_ACC,
    ST_CLOSE_READ,
    ST_CLOSE_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 operation;
    logic [PT_W-1:0]      from_point;
    logic [PT_W-1:0]      to_point;
    logic [IN_DIST_W-1:0] distance_value;
    logic [PT_W-1:0]      ordinal;
    logic                 last_element;
  } in_item_t;

  typedef struct packed {
    logic [PT_W-1:0]  visited_point;
    logic [LEN_W-1:0] running_length;
    logic             path_done;
    logic             new_best;
    logic [LEN_W-1:0] best_length;
    logic             bad_ordinal;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic [PT_W-1:0] k;
  } kth_ctl_t;

  typedef struct packed {
    logic            done;
    logic [PT_W-1:0] point;
  } kth_res_t;

endpackage
`default_nettype wire

FILE: hdl/otdl_kth.sv
`default_nettype none
// k-th set bit of the mask, one chunk per cycle
module otdl_kth (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire otdl_pkg::kth_ctl_t           ctl,
  input  wire logic [otdl_pkg::MASK_W-1:0]  mask,
  output otdl_pkg::kth_res_t                res
);

  logic [otdl_pkg::CIDX_W-1:0]  chunk_r;
  logic [otdl_pkg::PT_W-1:0]    k_r;
  logic                         run_r;
  logic [otdl_pkg::CHUNK_W-1:0] chunk;
  logic [otdl_pkg::SUB_W:0]     cnt;
  logic                         found;
  logic [otdl_pkg::SUB_W-1:0]   pos;

  function automatic logic [otdl_pkg::SUB_W:0] popc(
    input logic [otdl_pkg::CHUNK_W-1:0] c
  );
    logic [otdl_pkg::SUB_W:0] n;
    n = '0;
    for (int i = 0; i < otdl_pkg::CHUNK_W; i++) begin
      n = n + {{otdl_pkg::SUB_W{1'b0}}, c[i]};
    end
    return n;
  endfunction

  function automatic logic [otdl_pkg::SUB_W-1:0] pick(
    input logic [otdl_pkg::CHUNK_W-1:0] c,
    input logic [otdl_pkg::SUB_W-1:0]   k
  );
    logic [otdl_pkg::SUB_W:0]   seen;
    logic [otdl_pkg::SUB_W-1:0] p;
    seen = '0;
    p    = '0;
    for (int i = 0; i < otdl_pkg::CHUNK_W; i++) begin
      if (c[i]) begin
        if (seen == {1'b0, k}) begin
          p = otdl_pkg::SUB_W'(i);
        end
        seen = seen + 1'b1;
      end
    end
    return p;
  endfunction

  always_comb begin
    chunk = mask[chunk_r*otdl_pkg::CHUNK_W +: otdl_pkg::CHUNK_W];
    cnt   = popc(chunk);
    found = k_r < otdl_pkg::PT_W'(cnt);
    pos   = pick(chunk, k_r[otdl_pkg::SUB_W-1:0]);
    res.done  = run_r && found;
    res.point = otdl_pkg::PT_W'({chunk_r, pos});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      chunk_r <= '0;
      k_r     <= '0;
    end else if (ctl.start) begin
      run_r   <= 1'b1;
      chunk_r <= '0;
      k_r     <= ctl.k;
    end else if (run_r) begin
      if (found) begin
        run_r <= 1'b0;
      end else begin
        chunk_r <= chunk_r + 1'b1;
        k_r     <= k_r - otdl_pkg::PT_W'(cnt);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/otdl_dist_mem.sv
`default_nettype none
module otdl_dist_mem #(
  parameter int MAX_POINTS = otdl_pkg::MAX_POINTS_DEF,
  parameter int DIST_BITS  = otdl_pkg::DIST_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [otdl_pkg::PT_W-1:0]  wr_row,
  input  wire logic [otdl_pkg::PT_W-1:0]  wr_col,
  input  wire logic [DIST_BITS-1:0]       wr_data,
  input  wire logic [otdl_pkg::PT_W-1:0]  rd_row,
  input  wire logic [otdl_pkg::PT_W-1:0]  rd_col,
  output logic      [DIST_BITS-1:0]       rd_data
);

  localparam int DEPTH = MAX_POINTS * MAX_POINTS;
  localparam int AW    = $clog2(DEPTH);

  logic [DIST_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic                 wr_ok;

  always_comb begin
    wr_ok   = (32'(wr_row) < MAX_POINTS) && (32'(wr_col) < MAX_POINTS);
    wr_addr = AW'(32'(wr_row) * MAX_POINTS + 32'(wr_col));
    rd_addr = AW'(32'(rd_row) * MAX_POINTS + 32'(rd_col));
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: hdl/ordinal_tour_decode_length.sv
`default_nettype none
// Ordinal tour decoder with tour length and best-length tracking.
// Input: an item is taken when start is high and busy is low. Operation
// write stores one distance entry in that cycle and leaves busy low, so
// writes can follow each other with no gap.
// Operation path decodes one ordinal element of the current tour.
// Output: each path element gives one item on out_item, with out_valid
// high for exactly one cycle; the receiver cannot stall, so it must take
// the item in that cycle. Writes give no output.
// A path element passes these states: the first element, or one with no
// point left, goes straight to the output state (through the close read
// and accumulate if it also closes the tour); otherwise the k-th-bit unit
// walks the 8-bit mask chunks (1..8 of them) until it finds the point,
// then a distance read and accumulate follow, plus a second distance read
// when the element closes the tour. busy stays high through the output
// cycle, so the next item is taken in the cycle after it at the earliest.
// cfg_data is written whenever cfg_we is high and takes effect when the
// next tour starts. Reset clears the tour state and the best length and
// sets point_count to 6; the distance store is not cleared.
module ordinal_tour_decode_length #(
  parameter int MAX_POINTS = otdl_pkg::MAX_POINTS_DEF,
  parameter int DIST_BITS  = otdl_pkg::DIST_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire otdl_pkg::in_item_t          in_item,
  output logic                             out_valid,
  output otdl_pkg::out_item_t              out_item,
  input  wire logic                        cfg_we,
  input  wire logic [otdl_pkg::PC_W-1:0]   cfg_data
);

  localparam int POINT_LIMIT = (MAX_POINTS < 64) ? MAX_POINTS : 64;
  localparam int SUM_W = ((DIST_BITS > otdl_pkg::LEN_W) ? DIST_BITS : otdl_pkg::LEN_W) + 1;

  otdl_pkg::state_t             state_r, state_nxt;
  logic [otdl_pkg::PC_W-1:0]    pc_r;
  logic                         in_path_r;
  logic [otdl_pkg::MASK_W-1:0]  mask_r;
  logic [otdl_pkg::PT_W-1:0]    rem_r;
  logic [otdl_pkg::PT_W-1:0]    pt_r;
  logic [otdl_pkg::PT_W-1:0]    prev_r;
  logic [otdl_pkg::LEN_W-1:0]   len_r;
  logic [otdl_pkg::LEN_W-1:0]   best_r;
  logic                         last_r;
  logic                         bad_r;

  logic                         take_path;
  logic                         direct;
  logic                         ord_bad;
  logic [otdl_pkg::PT_W-1:0]    ord_k;
  logic [otdl_pkg::PC_W-1:0]    eff;
  logic [otdl_pkg::MASK_W-1:0]  fresh;
  logic                         mem_we;
  logic [otdl_pkg::PT_W-1:0]    rd_row;
  logic [DIST_BITS-1:0]         rd_data;
  logic [SUM_W-1:0]             sum;
  logic [otdl_pkg::LEN_W-1:0]   sat_len;
  logic                         improved;
  otdl_pkg::kth_ctl_t           kth_ctl;
  otdl_pkg::kth_res_t           kth_res;

  always_comb begin
    take_path = (state_r == otdl_pkg::ST_IDLE) && start
                && (in_item.operation == otdl_pkg::OP_PATH);
    direct    = !in_path_r || (rem_r == '0);
    ord_bad   = in_item.ordinal >= rem_r;
    ord_k     = ord_bad ? (rem_r - 1'b1) : in_item.ordinal;
    if (pc_r < 7'd2) begin
      eff = 7'd2;
    end else if (pc_r > otdl_pkg::PC_W'(POINT_LIMIT)) begin
      eff = otdl_pkg::PC_W'(POINT_LIMIT);
    end else begin
      eff = pc_r;
    end
    for (int i = 0; i < otdl_pkg::MASK_W; i++) begin
      fresh[i] = (i != 0) && (otdl_pkg::PC_W'(i) < eff);
    end
    sum      = SUM_W'(len_r) + SUM_W'(rd_data);
    sat_len  = (sum > SUM_W'(otdl_pkg::LEN_MAX)) ? otdl_pkg::LEN_MAX
                                                 : otdl_pkg::LEN_W'(sum);
    improved = last_r && ((best_r == '0) || (len_r < best_r));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      otdl_pkg::ST_IDLE: begin
        if (take_path) begin
          if (direct) begin
            state_nxt = in_item.last_element ? otdl_pkg::ST_CLOSE_READ : otdl_pkg::ST_OUT;
          end else begin
            state_nxt = otdl_pkg::ST_SCAN;
          end
        end
      end
      otdl_pkg::ST_SCAN: begin
        if (kth_res.done) begin
          state_nxt = otdl_pkg::ST_READ;
        end
      end
      otdl_pkg::ST_READ:       state_nxt = otdl_pkg::ST_ACC;
      otdl_pkg::ST_ACC: begin
        state_nxt = last_r ? otdl_pkg::ST_CLOSE_READ : otdl_pkg::ST_OUT;
      end
      otdl_pkg::ST_CLOSE_READ: state_nxt = otdl_pkg::ST_CLOSE_ACC;
      otdl_pkg::ST_CLOSE_ACC:  state_nxt = otdl_pkg::ST_OUT;
      otdl_pkg::ST_OUT:        state_nxt = otdl_pkg::ST_IDLE;
      default:                 state_nxt = otdl_pkg::ST_IDLE;
    endcase
  end

  // outputs and unit control
  always_comb begin
    busy          = (state_r != otdl_pkg::ST_IDLE);
    mem_we        = (state_r == otdl_pkg::ST_IDLE) && start
                    && (in_item.operation == otdl_pkg::OP_WRITE);
    kth_ctl.start = take_path && !direct;
    kth_ctl.k     = ord_k;
    rd_row        = prev_r;
    case (state_r)
      otdl_pkg::ST_CLOSE_READ: rd_row = '0;
      default:                 rd_row = prev_r;
    endcase
    out_valid               = (state_r == otdl_pkg::ST_OUT);
    out_item.visited_point  = pt_r;
    out_item.running_length = len_r;
    out_item.path_done      = last_r;
    out_item.new_best       = improved;
    out_item.best_length    = improved ? len_r : best_r;
    out_item.bad_ordinal    = bad_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= otdl_pkg::ST_IDLE;
      pc_r      <= otdl_pkg::PC_RESET;
      in_path_r <= 1'b0;
      best_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        pc_r <= cfg_data;
      end
      if (take_path) begin
        in_path_r <= 1'b1;
      end
      if (out_valid) begin
        if (improved) begin
          best_r <= len_r;
        end
        if (last_r) begin
          in_path_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      otdl_pkg::ST_IDLE: begin
        if (take_path) begin
          last_r <= in_item.last_element;
          if (!in_path_r) begin
            pt_r   <= '0;
            prev_r <= '0;
            len_r  <= '0;
            mask_r <= fresh;
            rem_r  <= otdl_pkg::PT_W'(eff - 1'b1);
            bad_r  <= 1'b0;
          end else if (rem_r == '0) begin
            pt_r  <= prev_r;
            bad_r <= 1'b1;
          end else begin
            bad_r <= ord_bad;
          end
        end
      end
      otdl_pkg::ST_SCAN: begin
        if (kth_res.done) begin
          pt_r                  <= kth_res.point;
          mask_r[kth_res.point] <= 1'b0;
          rem_r                 <= rem_r - 1'b1;
        end
      end
      otdl_pkg::ST_ACC, otdl_pkg::ST_CLOSE_ACC: begin
        len_r <= sat_len;
      end
      otdl_pkg::ST_OUT: begin
        prev_r <= last_r ? '0 : pt_r;
      end
      default: begin
      end
    endcase
  end

  otdl_kth u_kth (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (kth_ctl),
    .mask  (mask_r),
    .res   (kth_res)
  );

  otdl_dist_mem #(
    .MAX_POINTS (MAX_POINTS),
    .DIST_BITS  (DIST_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_row  (in_item.from_point),
    .wr_col  (in_item.to_point),
    .wr_data (DIST_BITS'(in_item.distance_value)),
    .rd_row  (rd_row),
    .rd_col  (pt_r),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire
